/* rtl/core/dfst_pkg.sv */
`default_nettype none
package dfst_pkg;
    localparam int MAX_VERTICES_DEF = 32;
    localparam int VW = 6;
    localparam int TW = 7;
    localparam int EW = 10;
    localparam logic [EW-1:0] EDGE_MAX = 10'd1023;
    localparam logic [5:0] VCOUNT_RESET = 6'd32;

    typedef enum logic [1:0] {
        REQ_ARC    = 2'd0,
        REQ_EDGE   = 2'd1,
        REQ_APPEND = 2'd2,
        REQ_RUN    = 2'd3
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROOT,
        ST_SCAN,
        ST_EMIT_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic run_start;
        logic root_step;
        logic scan_step;
        logic run_end;
        logic emit_rd;
        logic emit_done;
    } cmd_t;

    typedef struct packed {
        logic roots_done;
        logic stack_empty;
        logic emit_empty;
        logic emit_last;
    } status_t;
endpackage
`default_nettype wire

/* rtl/core/dfst_ctrl.sv */
`default_nettype none
module dfst_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [1:0]        in_type,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire dfst_pkg::status_t sts,
    output dfst_pkg::cmd_t         cmd
);
    dfst_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= dfst_pkg::ST_IDLE;
        else state_reg <= state_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            dfst_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_type == dfst_pkg::REQ_RUN) begin
                        cmd.run_start = 1'b1;
                        state_next = dfst_pkg::ST_ROOT;
                    end else cmd.load = 1'b1;
                end
            end
            dfst_pkg::ST_ROOT: begin
                if (sts.roots_done) begin
                    cmd.run_end = 1'b1;
                    if (sts.emit_empty) state_next = dfst_pkg::ST_IDLE;
                    else begin
                        cmd.emit_rd = 1'b1;
                        state_next = dfst_pkg::ST_EMIT;
                    end
                end else begin
                    cmd.root_step = 1'b1;
                    state_next = dfst_pkg::ST_SCAN;
                end
            end
            dfst_pkg::ST_SCAN: begin
                if (sts.stack_empty) state_next = dfst_pkg::ST_ROOT;
                else cmd.scan_step = 1'b1;
            end
            dfst_pkg::ST_EMIT_RD: begin
                cmd.emit_rd = 1'b1;
                state_next = dfst_pkg::ST_EMIT;
            end
            dfst_pkg::ST_EMIT: begin
                out_valid = 1'b1;
                if (out_ready) begin
                    cmd.emit_done = 1'b1;
                    state_next = sts.emit_last ? dfst_pkg::ST_IDLE : dfst_pkg::ST_EMIT_RD;
                end
            end
            default: state_next = dfst_pkg::ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/core/dfst_dp.sv */
`default_nettype none
module dfst_dp #(
    parameter int MAX_VERTICES = dfst_pkg::MAX_VERTICES_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_we,
    input  wire logic [5:0]             cfg_wdata,
    input  wire logic [1:0]             in_type,
    input  wire logic [dfst_pkg::VW-1:0] in_from,
    input  wire logic [dfst_pkg::VW-1:0] in_to,
    input  wire dfst_pkg::cmd_t         cmd,
    output dfst_pkg::status_t           sts,
    output logic [dfst_pkg::VW-1:0]     o_vertex,
    output logic [dfst_pkg::TW-1:0]     o_disc,
    output logic [dfst_pkg::TW-1:0]     o_fin,
    output logic [dfst_pkg::VW-1:0]     o_parent,
    output logic [dfst_pkg::EW-1:0]     o_edges,
    output logic                        o_last
);
    localparam int N = MAX_VERTICES;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);
    localparam int VW = dfst_pkg::VW;
    localparam int TW = dfst_pkg::TW;

    logic [5:0]      vcount_reg;
    logic [N-1:0]    adj_reg [N];
    logic [N-1:0]    white_reg;
    logic [VW-1:0]   par_reg [N];
    logic [TW-1:0]   disc_reg [N];
    logic [TW-1:0]   fin_reg [N];
    logic [TW-1:0]   time_reg;
    logic [dfst_pkg::EW-1:0] edges_reg;
    logic [VW-1:0]   order_mem [N];
    logic [CW-1:0]   olen_reg;
    logic [CW-1:0]   oidx_reg;
    logic [VW-1:0]   finl_reg [N];
    logic [CW-1:0]   done_reg;
    logic [VW-1:0]   stk_reg [N];
    logic [CW-1:0]   sp_reg;
    logic [CW-1:0]   eidx_reg;
    logic [VW-1:0]   ov_reg;

    logic [CW-1:0] n;
    logic [N-1:0]  nmask;
    logic          a_ok, b_ok;
    logic [VW-1:0] root;
    logic          root_ok;
    logic [VW-1:0] top;
    logic [N-1:0]  cand;
    logic          found;
    logic [IW-1:0] fidx;

    always_comb begin
        if (vcount_reg == 6'd0) n = CW'(1);
        else if ({1'b0, vcount_reg} > 7'(N)) n = CW'(N);
        else n = CW'(vcount_reg);
        for (int i = 0; i < N; i++) nmask[i] = (CW'(i) < n);
        a_ok = (in_from != '0) && ({1'b0, in_from} <= 7'(n));
        b_ok = (in_to != '0) && ({1'b0, in_to} <= 7'(n));
        root = order_mem[oidx_reg[IW-1:0]];
        root_ok = (root != '0) && ({1'b0, root} <= 7'(n))
                  && white_reg[IW'(root - 6'd1)];
        top = stk_reg[IW'(sp_reg - CW'(1))];
        cand = adj_reg[IW'(top - 6'd1)] & white_reg & nmask;
        found = |cand;
        fidx = '0;
        for (int i = N - 1; i >= 0; i--) if (cand[i]) fidx = IW'(i);
    end

    assign sts.roots_done  = (oidx_reg >= olen_reg);
    assign sts.stack_empty = (sp_reg == '0);
    assign sts.emit_empty  = (done_reg == '0);
    assign sts.emit_last   = (eidx_reg == done_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= dfst_pkg::VCOUNT_RESET;
            edges_reg <= '0;
            olen_reg <= '0;
            oidx_reg <= '0;
            sp_reg <= '0;
            done_reg <= '0;
            eidx_reg <= '0;
            time_reg <= '0;
            white_reg <= '1;
            for (int i = 0; i < N; i++) adj_reg[i] <= '0;
        end else begin
            if (cfg_we) vcount_reg <= cfg_wdata;
            if (cmd.load) begin
                if (in_type == dfst_pkg::REQ_APPEND) begin
                    if (a_ok && olen_reg < CW'(N)) begin
                        order_mem[olen_reg[IW-1:0]] <= in_from;
                        olen_reg <= olen_reg + CW'(1);
                    end
                end else if (a_ok && b_ok) begin
                    adj_reg[IW'(in_from - 6'd1)][IW'(in_to - 6'd1)] <= 1'b1;
                    if (in_type == dfst_pkg::REQ_EDGE)
                        adj_reg[IW'(in_to - 6'd1)][IW'(in_from - 6'd1)] <= 1'b1;
                    if (edges_reg != dfst_pkg::EDGE_MAX) edges_reg <= edges_reg + 1'b1;
                end
            end
            if (cmd.run_start) begin
                white_reg <= '1;
                time_reg <= '0;
                sp_reg <= '0;
                oidx_reg <= '0;
                done_reg <= '0;
            end
            if (cmd.root_step) begin
                oidx_reg <= oidx_reg + CW'(1);
                if (root_ok) begin
                    white_reg[IW'(root - 6'd1)] <= 1'b0;
                    disc_reg[IW'(root - 6'd1)] <= time_reg + 1'b1;
                    par_reg[IW'(root - 6'd1)] <= '0;
                    time_reg <= time_reg + 1'b1;
                    stk_reg[sp_reg[IW-1:0]] <= root;
                    sp_reg <= sp_reg + CW'(1);
                end
            end
            if (cmd.scan_step) begin
                time_reg <= time_reg + 1'b1;
                if (found) begin
                    // ascending scan over white neighbours equals resumed scan
                    white_reg[fidx] <= 1'b0;
                    disc_reg[fidx] <= time_reg + 1'b1;
                    par_reg[fidx] <= top;
                    stk_reg[sp_reg[IW-1:0]] <= VW'(fidx) + 6'd1;
                    sp_reg <= sp_reg + CW'(1);
                end else begin
                    fin_reg[IW'(top - 6'd1)] <= time_reg + 1'b1;
                    finl_reg[done_reg[IW-1:0]] <= top;
                    done_reg <= done_reg + CW'(1);
                    sp_reg <= sp_reg - CW'(1);
                end
            end
            if (cmd.emit_rd) begin
                ov_reg <= finl_reg[IW'(done_reg - eidx_reg - CW'(1))];
                eidx_reg <= eidx_reg + CW'(1);
            end
            if (cmd.emit_done) begin
                order_mem[IW'(eidx_reg - CW'(1))] <= ov_reg;
                if (eidx_reg == done_reg) begin
                    olen_reg <= done_reg;
                    eidx_reg <= '0;
                end
            end
            // the finish list, possibly empty, becomes the new order length
            if (cmd.run_end) olen_reg <= done_reg;
        end
    end

    always_comb begin
        o_vertex = ov_reg;
        o_disc = disc_reg[IW'(ov_reg - 6'd1)];
        o_fin = fin_reg[IW'(ov_reg - 6'd1)];
        o_parent = par_reg[IW'(ov_reg - 6'd1)];
        o_edges = edges_reg;
        o_last = (eidx_reg == done_reg);
    end
endmodule
`default_nettype wire

/* rtl/core/depth_first_search_timestamps.sv */
// a run searches from each listed root in turn through the stack, then reports each finished vertex
// throughput: one load item per cycle; one run at a time, input held until results end
// the search loop advances one discovery or finish per cycle through the stack
// reset: synchronous active-low aresetn clears graph, counters and order list
`default_nettype none
module depth_first_search_timestamps #(
    parameter int MAX_VERTICES = dfst_pkg::MAX_VERTICES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [5:0]  cfg_wdata,     // vertex_count
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,       // req_type
    input  wire logic [15:0] s_tdata,       // from_vertex[5:0], to_vertex[11:6], zero pad
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,       // vertex, discover, finish, parent, edges, pad
    output logic             m_tlast
);
    dfst_pkg::cmd_t    cmd;
    dfst_pkg::status_t sts;
    logic [5:0] o_vertex, o_parent;
    logic [6:0] o_disc, o_fin;
    logic [9:0] o_edges;
    logic       o_last;

    // controller sequences load, search and report phases
    dfst_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_tvalid), .in_type(s_tuser),
        .in_ready(s_tready), .out_valid(m_tvalid), .out_ready(m_tready),
        .sts(sts), .cmd(cmd)
    );

    // datapath holds matrix, stack and per-vertex records
    dfst_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_type(s_tuser), .in_from(s_tdata[5:0]), .in_to(s_tdata[11:6]),
        .cmd(cmd), .sts(sts), .o_vertex(o_vertex), .o_disc(o_disc), .o_fin(o_fin),
        .o_parent(o_parent), .o_edges(o_edges), .o_last(o_last)
    );

    assign m_tdata = {4'd0, o_edges, o_parent, o_fin, o_disc, o_vertex};
    assign m_tlast = o_last;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
    a_no_in_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input taken while reporting");
endmodule
`default_nettype wire
